@@ design/rotated_box_extent_macros.svh @@
// ----------------------------------------------------------------------------
// rotated_box_extent_macros: assertion macros
// Assertion macros used by the checker file of the rotated box extent block.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BOX_EXTENT_MACROS_SVH
`define ROTATED_BOX_EXTENT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RBE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rotated_box_extent: assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define RBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotated_box_extent: assertion failed");

`endif

@@ design/rbe_pkg.sv @@
// ----------------------------------------------------------------------------
// rbe_pkg: rotated box extent package
// Request and result types, fixed widths and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned COORD_W             = 20;
  localparam int unsigned YAW_W               = 16;
  localparam int unsigned SINE_W              = 16;  // signed Q1.14
  localparam int unsigned SINE_MAG_W          = 15;  // magnitude 0 .. 16384
  localparam int unsigned SINE_INDEX_BITS_DEF = 10;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                      box_valid;
    logic        [YAW_W-1:0]   yaw_turn;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_min_x;
    logic signed [COORD_W-1:0] out_max_x;
    logic signed [COORD_W-1:0] out_min_y;
    logic signed [COORD_W-1:0] out_max_y;
  } out_item_t;

  // Sine of (r / 2^qbits) quarter turns in Q1.14, from a truncating
  // eight-term Taylor series in Q2.30. Used at elaboration only.
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned r,
                                                         input int unsigned qbits);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(r)) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return SINE_MAG_W'((64'(sum) + 64'd32768) >> 16);
  endfunction

endpackage

@@ design/rbe_stream_if.sv @@
// ----------------------------------------------------------------------------
// rbe_stream_if: valid/ready request channel
// Carries one request payload of type T with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rbe_sincos.sv @@
// ----------------------------------------------------------------------------
// rbe_sincos: sine and cosine lookup
// Quarter-wave constant table folded to a full turn, read for sine and cosine.
// ----------------------------------------------------------------------------
module rbe_sincos import rbe_pkg::*; #(
  parameter int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
  input  logic        [YAW_W-1:0]  yaw_turn_i,
  output logic signed [SINE_W-1:0] sin_o,
  output logic signed [SINE_W-1:0] cos_o
);

  localparam int unsigned QBITS   = SINE_INDEX_BITS - 2;
  localparam int unsigned QUARTER = 1 << QBITS;
  localparam logic [QBITS:0] QUARTER_A = {1'b1, {QBITS{1'b0}}};

  logic [SINE_MAG_W-1:0] qsine_tab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign qsine_tab[k] = quarter_sine(k, QBITS);
  end

  logic [SINE_INDEX_BITS-1:0] idx;
  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [QBITS-1:0]           rem;
  logic [QBITS:0]             addr_s;
  logic [QBITS:0]             addr_c;
  logic [SINE_MAG_W-1:0]      mag_s;
  logic [SINE_MAG_W-1:0]      mag_c;

  always_comb begin
    idx    = yaw_turn_i[YAW_W-1 -: SINE_INDEX_BITS];
    quad_s = idx[SINE_INDEX_BITS-1 -: 2];
    quad_c = quad_s + 2'd1;  // cosine sits a quarter turn on
    rem    = idx[QBITS-1:0];
    addr_s = quad_s[0] ? (QUARTER_A - {1'b0, rem}) : {1'b0, rem};
    addr_c = quad_c[0] ? (QUARTER_A - {1'b0, rem}) : {1'b0, rem};
    mag_s  = qsine_tab[addr_s];
    mag_c  = qsine_tab[addr_c];
    sin_o  = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    cos_o  = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

endmodule

@@ design/rotated_box_extent.sv @@
// ----------------------------------------------------------------------------
// rotated_box_extent: axis-aligned extent of a yawed 2-D box
// Rotates the four corners of a box and reports their bounding extent.
// ----------------------------------------------------------------------------
// Each request on in_i carries an axis-aligned box in signed Q16.4 and a yaw
// angle in 1/65536 of a turn. The block rotates the four corners about the
// origin with a Q1.14 sine and cosine, rounds every product half up, saturates
// every sum to the 20-bit range and returns the least and greatest rotated x
// and y on out_o. A request with box_valid low is taken and produces nothing.
// The datapath is five register stages: input, sine/cosine lookup, products,
// rotated corners and result, passed in that order. One request is taken
// every cycle unless a stalled result has filled the stages behind it; each
// stage only waits when the stage after it is full and stalled, so bubbles
// are squeezed out behind a stalled result. The lookup stage holds a constant
// table of 2^(SINE_INDEX_BITS-2)+1 entries, read at once for sine and cosine.
// ----------------------------------------------------------------------------
module rotated_box_extent import rbe_pkg::*; #(
  parameter int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rbe_stream_if.sink   in_i,
  rbe_stream_if.source out_o
);

  localparam int unsigned PROD_FULL_W = SINE_W + COORD_W;
  localparam int unsigned PROD_W      = PROD_FULL_W - 14;
  localparam int unsigned PSUM_W      = PROD_W + 1;

  // Rounds a Q.18 product half up back onto the coordinate grid.
  function automatic logic signed [PROD_W-1:0] round_q14(
      input logic signed [PROD_FULL_W-1:0] p);
    logic signed [PROD_FULL_W-1:0] biased;
    biased = p + PROD_FULL_W'(8192);
    return biased[PROD_FULL_W-1:14];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [PSUM_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > PSUM_W'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (v < PSUM_W'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en_out;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;

  assign en_out     = !out_v_q || out_o.ready;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  // Stage 1: input register.
  logic        [YAW_W-1:0]   yaw_q;
  logic signed [COORD_W-1:0] bx1_q [2];
  logic signed [COORD_W-1:0] by1_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid && in_i.data.box_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      yaw_q    <= in_i.data.yaw_turn;
      bx1_q[0] <= in_i.data.box_min_x;
      bx1_q[1] <= in_i.data.box_max_x;
      by1_q[0] <= in_i.data.box_min_y;
      by1_q[1] <= in_i.data.box_max_y;
    end
  end

  // Stage 2: sine and cosine of the truncated table index.
  logic signed [SINE_W-1:0]  sin_d, cos_d;
  logic signed [SINE_W-1:0]  sin_q, cos_q;
  logic signed [COORD_W-1:0] bx2_q [2];
  logic signed [COORD_W-1:0] by2_q [2];

  rbe_sincos #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sincos (
    .yaw_turn_i (yaw_q),
    .sin_o      (sin_d),
    .cos_o      (cos_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
      bx2_q <= bx1_q;
      by2_q <= by1_q;
    end
  end

  // Stage 3: the eight rounded products, one multiplier each.
  logic signed [PROD_W-1:0] cbx_q [2];
  logic signed [PROD_W-1:0] sbx_q [2];
  logic signed [PROD_W-1:0] sby_q [2];
  logic signed [PROD_W-1:0] cby_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int i = 0; i < 2; i++) begin
        cbx_q[i] <= round_q14(PROD_FULL_W'(cos_q) * PROD_FULL_W'(bx2_q[i]));
        sbx_q[i] <= round_q14(PROD_FULL_W'(sin_q) * PROD_FULL_W'(bx2_q[i]));
        sby_q[i] <= round_q14(PROD_FULL_W'(sin_q) * PROD_FULL_W'(by2_q[i]));
        cby_q[i] <= round_q14(PROD_FULL_W'(cos_q) * PROD_FULL_W'(by2_q[i]));
      end
    end
  end

  // Stage 4: saturated rotated corners, corner 2*i+j pairs x bound i with y bound j.
  logic signed [COORD_W-1:0] tx_q [4];
  logic signed [COORD_W-1:0] ty_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          tx_q[2*i+j] <= sat_coord(PSUM_W'(cbx_q[i]) - PSUM_W'(sby_q[j]));
          ty_q[2*i+j] <= sat_coord(PSUM_W'(sbx_q[i]) + PSUM_W'(cby_q[j]));
        end
      end
    end
  end

  // Result stage: two-level min/max trees over the four corners.
  logic signed [COORD_W-1:0] mnx_a, mnx_b, mxx_a, mxx_b;
  logic signed [COORD_W-1:0] mny_a, mny_b, mxy_a, mxy_b;
  out_item_t                 res_d;
  out_item_t                 res_q;

  always_comb begin
    mnx_a = (tx_q[1] < tx_q[0]) ? tx_q[1] : tx_q[0];
    mnx_b = (tx_q[3] < tx_q[2]) ? tx_q[3] : tx_q[2];
    mxx_a = (tx_q[1] > tx_q[0]) ? tx_q[1] : tx_q[0];
    mxx_b = (tx_q[3] > tx_q[2]) ? tx_q[3] : tx_q[2];
    mny_a = (ty_q[1] < ty_q[0]) ? ty_q[1] : ty_q[0];
    mny_b = (ty_q[3] < ty_q[2]) ? ty_q[3] : ty_q[2];
    mxy_a = (ty_q[1] > ty_q[0]) ? ty_q[1] : ty_q[0];
    mxy_b = (ty_q[3] > ty_q[2]) ? ty_q[3] : ty_q[2];
    res_d.out_min_x = (mnx_b < mnx_a) ? mnx_b : mnx_a;
    res_d.out_max_x = (mxx_b > mxx_a) ? mxx_b : mxx_a;
    res_d.out_min_y = (mny_b < mny_a) ? mny_b : mny_a;
    res_d.out_max_y = (mxy_b > mxy_a) ? mxy_b : mxy_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && v4_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = res_q;

endmodule

@@ design/rbe_checker.sv @@
// ----------------------------------------------------------------------------
// rbe_checker: port checks for the rotated box extent block
// Watches the result channel and the extent ordering it reports.
// ----------------------------------------------------------------------------
`include "rotated_box_extent_macros.svh"

module rbe_checker import rbe_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A stalled result stays offered and unchanged.
  `RBE_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RBE_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

  // Min and max are taken over the same four corners, so the extent can never come out inverted.
  `RBE_ASSERT(a_x_order, clk_i, rst_ni, !out_valid_i || (out_data_i.out_min_x <= out_data_i.out_max_x))
  `RBE_ASSERT(a_y_order, clk_i, rst_ni, !out_valid_i || (out_data_i.out_min_y <= out_data_i.out_max_y))

endmodule

bind rotated_box_extent rbe_checker u_rbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
